// ===== rtl/nala_pkg.sv =====
// ============================================================================
// nala_pkg
// Shared types, codes and helpers of the neighbour average level agent.
// ============================================================================
package nala_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W  = 2;
    localparam int PORT_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 4;
    localparam int SERVO_W = 7;

    // Framing.
    localparam int FRAME_LEN   = 4;
    localparam int MAX_RESULTS = 12;
    localparam int MAX_GROUPS  = MAX_RESULTS / FRAME_LEN;

    localparam logic [BYTE_W-1:0] BYTE_SYNC = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ECHO = 8'hFE;
    localparam logic [BYTE_W-1:0] BYTE_TAIL = 8'hAA;

    // Servo scaling: level * 100 / 8, saturated at 100.
    localparam int SERVO_SCALE = 100;
    localparam int SERVO_SHIFT = 3;
    localparam int SERVO_MAX   = 100;
    localparam int SERVO_PROD_W = LEVEL_W + 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX     = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_BEACON = 2'd2
    } t_kind;

    // Byte position inside a 4-byte frame.
    typedef enum logic [1:0] {
        FPOS_HEAD = 2'd0,
        FPOS_ID   = 2'd1,
        FPOS_VAL  = 2'd2,
        FPOS_TAIL = 2'd3
    } t_fpos;

    // Command from the frame logic to the level tracker.
    typedef struct packed {
        logic              button;
        logic              report;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] val;
    } t_lvl_cmd;

    function automatic logic [SERVO_W-1:0] servo_of(input logic [LEVEL_W-1:0] lvl);
        logic [SERVO_PROD_W-1:0] prod;
        logic [SERVO_PROD_W-SERVO_SHIFT-1:0] q;
        prod = SERVO_PROD_W'(lvl) * SERVO_PROD_W'(SERVO_SCALE);
        q    = prod[SERVO_PROD_W-1:SERVO_SHIFT];
        if (q > (SERVO_PROD_W-SERVO_SHIFT)'(SERVO_MAX)) begin
            return SERVO_W'(SERVO_MAX);
        end
        return q[SERVO_W-1:0];
    endfunction

endpackage

// ===== rtl/nala_level.sv =====
// ============================================================================
// nala_level
// Own level tracker: neighbour slots, own slot and the step toward the mean.
// ============================================================================
module nala_level
    import nala_pkg::*;
#(
    parameter int PORTS     = 3,
    parameter int LED_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lvl_cmd           i_cmd,
    output logic [LEVEL_W-1:0] o_level_next
);

    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int CNT_W  = $clog2(PORTS + 2);
    localparam int SUM_W  = BYTE_W + $clog2(PORTS + 1);
    localparam int TGT_W  = LEVEL_W + CNT_W;
    localparam int CMP_W  = ((SUM_W > TGT_W) ? SUM_W : TGT_W) + 1;

    logic                r_nbr_vld [PORTS];
    logic [BYTE_W-1:0]   r_nbr_val [PORTS];
    logic [BYTE_W-1:0]   r_own;
    logic [LEVEL_W-1:0]  r_level;

    logic                n_nbr_vld [PORTS];
    logic [BYTE_W-1:0]   n_nbr_val [PORTS];
    logic [BYTE_W-1:0]   n_own;
    logic [LEVEL_W-1:0]  n_level;

    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    cnt;
    logic [TGT_W-1:0]    target;
    logic                go_up;
    logic                go_down;
    logic [LEVEL_W-1:0]  lvl_up;
    logic [LEVEL_W-1:0]  lvl_down;

    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            n_nbr_vld[i] = r_nbr_vld[i];
            n_nbr_val[i] = r_nbr_val[i];
        end
        n_own = r_own;
        if (i_cmd.report) begin
            if (i_cmd.id < BYTE_W'(PORTS)) begin
                n_nbr_vld[PIDX_W'(i_cmd.id)] = 1'b1;
                n_nbr_val[PIDX_W'(i_cmd.id)] = i_cmd.val;
            end else if (i_cmd.id == BYTE_W'(PORTS)) begin
                n_own = i_cmd.val;
            end
        end

        // A neighbour slot counts only once it holds a positive report; the own slot always counts.
        sum = SUM_W'(n_own);
        cnt = CNT_W'(1);
        for (int i = 0; i < PORTS; i++) begin
            if (n_nbr_vld[i] && (n_nbr_val[i] != '0)) begin
                sum = sum + SUM_W'(n_nbr_val[i]);
                cnt = cnt + CNT_W'(1);
            end
        end
        target = TGT_W'(r_level) * TGT_W'(cnt);

        go_up   = i_cmd.button || (i_cmd.report && (CMP_W'(sum) > CMP_W'(target)));
        go_down = i_cmd.report && (CMP_W'(sum) < CMP_W'(target));

        lvl_up   = (r_level == LEVEL_W'(LED_COUNT)) ? '0 : r_level + LEVEL_W'(1);
        lvl_down = (r_level == '0) ? '0 : r_level - LEVEL_W'(1);

        n_level = r_level;
        if (go_up) begin
            n_level = lvl_up;
            n_own   = lvl_up;
        end else if (go_down) begin
            n_level = lvl_down;
            n_own   = lvl_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                r_nbr_vld[i] <= 1'b0;
            end
            r_own   <= '0;
            r_level <= '0;
        end else begin
            for (int i = 0; i < PORTS; i++) begin
                r_nbr_vld[i] <= n_nbr_vld[i];
            end
            r_own   <= n_own;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PORTS; i++) begin
            r_nbr_val[i] <= n_nbr_val[i];
        end
    end

    assign o_level_next = n_level;

endmodule

// ===== rtl/neighbour_average_level_agent.sv =====
// ============================================================================
// neighbour_average_level_agent
// Frame collector, level follower and transmit byte sequencer.
// ============================================================================
// An accepted beat lands in an input register and is handed to the result
// sequencer, whose run register takes it when the sequencer is free or gives
// up its last beat in that cycle. The first result beat is presented straight
// from the run register. The single result port gives one beat per cycle
// while the receiver takes them, so an item yields as many beats as it has
// results: four for a completed frame (the echo on port 0), four per port for
// a beacon (at most three ports, twelve beats), and one for every other item
// (a status beat with has_byte low). While a run is being sent, one further
// input beat waits in the input register and the input channel stalls until
// the run's last beat is taken; with one-beat items and a receiver that never
// stalls, a new input beat is taken in every cycle.
module neighbour_average_level_agent
    import nala_pkg::*;
#(
    parameter int PORTS     = 3,
    parameter int LED_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: own agent number.
    input  logic               i_cfg_we,
    input  logic [BYTE_W-1:0]  i_cfg_wdata,
    // Input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [PORT_W-1:0]  i_rx_port,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    // Result channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_has_byte,
    output logic [PORT_W-1:0]  o_tx_port,
    output logic [BYTE_W-1:0]  o_tx_byte,
    output logic [LEVEL_W-1:0] o_led_level,
    output logic [SERVO_W-1:0] o_servo_position,
    output logic               o_last_of_run
);

    localparam int PIDX_W     = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int BCN_GROUPS = (PORTS < MAX_GROUPS) ? PORTS : MAX_GROUPS;

    // Configuration register.
    logic [BYTE_W-1:0]  r_agent;

    // Input register.
    logic               r_in_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [PORT_W-1:0]  r_rx_port;
    logic [BYTE_W-1:0]  r_rx_byte;

    // Per-port frame assembly. Only the head flag and the id and value bytes
    // are kept; the tail byte is the one that completes the frame.
    logic [1:0]         r_fpos  [PORTS];
    logic               r_fhead [PORTS];
    logic [BYTE_W-1:0]  r_fid   [PORTS];
    logic [BYTE_W-1:0]  r_fval  [PORTS];

    // Result run descriptor.
    logic               r_run_valid;
    logic               r_run_has;
    logic               r_run_beacon;
    logic [BYTE_W-1:0]  r_run_head;
    logic [BYTE_W-1:0]  r_run_b1;
    logic [BYTE_W-1:0]  r_run_b2;
    logic [PORT_W-1:0]  r_run_last_grp;
    logic [PORT_W-1:0]  r_run_grp;
    logic [1:0]         r_run_idx;
    logic [LEVEL_W-1:0] r_run_level;
    logic [SERVO_W-1:0] r_run_servo;

    logic               run_load;
    logic               out_done;
    logic [PIDX_W-1:0]  pidx;
    logic               rx_ok;
    logic               is_sync;
    logic [1:0]         pos;
    logic               complete;
    logic               is_beacon;
    logic               is_button;
    t_lvl_cmd           lvl_cmd;
    logic [LEVEL_W-1:0] level_next;

    // ------------------------------------------------------------------------
    // Handshakes. The input register is free when empty or when its item is
    // handed to the sequencer in this cycle.
    // ------------------------------------------------------------------------
    assign out_done = o_valid && i_ready && o_last_of_run;
    assign run_load = r_in_valid && (!r_run_valid || out_done);
    assign o_ready  = !r_in_valid || run_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agent    <= '0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_agent <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind    <= i_kind;
            r_rx_port <= i_rx_port;
            r_rx_byte <= i_rx_byte;
        end
    end

    // ------------------------------------------------------------------------
    // Decode of the registered item. A byte on a port beyond the last one is
    // dropped; an unknown kind only yields a status beat.
    // ------------------------------------------------------------------------
    always_comb begin
        is_beacon = 1'b0;
        is_button = 1'b0;
        rx_ok     = 1'b0;
        unique case (t_kind'(r_kind))
            KIND_RX:     rx_ok     = ({2'b00, r_rx_port} < 4'(PORTS));
            KIND_BUTTON: is_button = 1'b1;
            KIND_BEACON: is_beacon = 1'b1;
            default:     ;
        endcase
    end

    assign pidx     = PIDX_W'(r_rx_port);
    assign pos      = rx_ok ? r_fpos[pidx] : 2'd0;
    assign is_sync  = (r_rx_byte == BYTE_SYNC);
    assign complete = rx_ok && !is_sync && (t_fpos'(pos) == FPOS_TAIL);

    // A sync byte always restarts the frame with its head already in place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                r_fpos[i] <= 2'd0;
            end
        end else if (run_load && rx_ok) begin
            if (is_sync) begin
                r_fpos[pidx] <= 2'd1;
            end else begin
                r_fpos[pidx] <= pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_load && rx_ok) begin
            if (is_sync) begin
                r_fhead[pidx] <= 1'b1;
            end else begin
                unique case (t_fpos'(pos))
                    FPOS_HEAD: r_fhead[pidx] <= 1'b0;
                    FPOS_ID:   r_fid[pidx]   <= r_rx_byte;
                    FPOS_VAL:  r_fval[pidx]  <= r_rx_byte;
                    FPOS_TAIL: ;
                    default:   ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Level tracking. Only a complete frame that opens with a sync byte is a
    // neighbour report; any complete frame is echoed.
    // ------------------------------------------------------------------------
    always_comb begin
        lvl_cmd.button = run_load && is_button;
        lvl_cmd.report = run_load && complete && r_fhead[pidx];
        lvl_cmd.id     = r_fid[pidx];
        lvl_cmd.val    = r_fval[pidx];
    end

    nala_level #(
        .PORTS     (PORTS),
        .LED_COUNT (LED_COUNT)
    ) u_level (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (lvl_cmd),
        .o_level_next (level_next)
    );

    // ------------------------------------------------------------------------
    // Result sequencer. A run is one status beat, or groups of four bytes:
    // head, first data byte, second data byte, tail. A beacon sends one group
    // per port, for at most three ports; the echo sends one group on port 0.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
        end else if (run_load) begin
            r_run_valid <= 1'b1;
        end else if (out_done) begin
            r_run_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_load) begin
            r_run_has    <= complete || is_beacon;
            r_run_beacon <= is_beacon;
            r_run_grp    <= '0;
            r_run_idx    <= '0;
            r_run_level  <= level_next;
            r_run_servo  <= servo_of(level_next);
            if (is_beacon) begin
                r_run_head     <= BYTE_SYNC;
                r_run_b1       <= r_agent;
                r_run_b2       <= BYTE_W'(level_next);
                r_run_last_grp <= PORT_W'(BCN_GROUPS - 1);
            end else begin
                r_run_head     <= BYTE_ECHO;
                r_run_b1       <= r_fid[pidx];
                r_run_b2       <= r_fval[pidx];
                r_run_last_grp <= '0;
            end
        end else if (o_valid && i_ready) begin
            r_run_idx <= r_run_idx + 2'd1;
            if (t_fpos'(r_run_idx) == FPOS_TAIL) begin
                r_run_grp <= r_run_grp + PORT_W'(1);
            end
        end
    end

    always_comb begin
        o_tx_byte = '0;
        if (r_run_has) begin
            case (t_fpos'(r_run_idx))
                FPOS_HEAD: o_tx_byte = r_run_head;
                FPOS_ID:   o_tx_byte = r_run_b1;
                FPOS_VAL:  o_tx_byte = r_run_b2;
                FPOS_TAIL: o_tx_byte = BYTE_TAIL;
                default:   o_tx_byte = '0;
            endcase
        end
    end

    assign o_valid          = r_run_valid;
    assign o_has_byte       = r_run_has;
    assign o_tx_port        = (r_run_has && r_run_beacon) ? r_run_grp : '0;
    assign o_led_level      = r_run_level;
    assign o_servo_position = r_run_servo;
    assign o_last_of_run    = !r_run_has
                              || ((t_fpos'(r_run_idx) == FPOS_TAIL)
                                  && (r_run_grp == r_run_last_grp));

endmodule

// ===== rtl/nala_checker.sv =====
// ============================================================================
// nala_checker
// Port-level checks of the agent's result stream, bound to the top level.
// ============================================================================
module nala_checker
    import nala_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic               o_has_byte,
    input  logic [PORT_W-1:0]  o_tx_port,
    input  logic [BYTE_W-1:0]  o_tx_byte,
    input  logic [LEVEL_W-1:0] o_led_level,
    input  logic [SERVO_W-1:0] o_servo_position,
    input  logic               o_last_of_run
);

    // A beat that carries no byte is a whole run of its own, zero filled.
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_last_of_run && (o_tx_byte == '0) && (o_tx_port == '0))
    else $error("status beat is not a lone zero beat");

    // A stalled beat holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte) && $stable(o_tx_port)
            && $stable(o_last_of_run) && $stable(o_led_level))
    else $error("result beat changed while stalled");

    // Runs are delivered without gaps and with one level throughout.
    a_run_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid && o_has_byte
            && (o_led_level == $past(o_led_level)))
    else $error("run broken or level changed inside a run");

    // The servo command always follows the level shown.
    a_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_servo_position == servo_of(o_led_level))
    else $error("servo position does not match level");

endmodule

bind neighbour_average_level_agent nala_checker u_nala_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_has_byte       (o_has_byte),
    .o_tx_port        (o_tx_port),
    .o_tx_byte        (o_tx_byte),
    .o_led_level      (o_led_level),
    .o_servo_position (o_servo_position),
    .o_last_of_run    (o_last_of_run)
);
